[rtl/assert_macros.svh]
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the palette table blocks.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked on aclk, off while reset is asserted.
`define PLTR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked on aclk at every edge, reset included.
`define PLTR_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define PLTR_ASSERT(lbl, prop, msg)
`define PLTR_ASSERT_NR(lbl, prop, msg)
`endif

`endif

[rtl/pltr_pkg.sv]
// -----------------------------------------------------------------------------
// Palette table package
// Widths, codes and controller/datapath interface types.
// -----------------------------------------------------------------------------
package pltr_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;

    localparam int IDX_W      = 8;
    localparam int CHAN_W     = 8;
    localparam int COLOR_W    = 3 * CHAN_W;
    localparam int LEN_W      = 9;
    localparam int BG_W       = 8;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam int SEARCH_MAX = 256;

    localparam logic [LEN_W-1:0] LENGTH_RESET = 9'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_ID  = 2'd1;

    typedef enum logic [OP_W-1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FIND  = 2'd2
    } op_t;

    typedef struct packed {
        logic clear_step;
        logic wr_item;
        logic rd_index;
        logic scan_start;
        logic scan_step;
        logic load_read;
        logic load_find;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic scan_hit;
        logic scan_last;
    } stat_t;

endpackage

[rtl/pltr_ram.sv]
// -----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// -----------------------------------------------------------------------------
module pltr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/pltr_ctrl.sv]
// -----------------------------------------------------------------------------
// Palette table controller
// Sequences the clearing pass, reads, writes and scans, and owns result valid.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module pltr_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [pltr_pkg::OP_W-1:0] s_operation,
    output logic                      m_valid,
    input  logic                      m_ready,
    input  pltr_pkg::stat_t           stat,
    output pltr_pkg::cmd_t            cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (pltr_pkg::op_t'(s_operation))
                        pltr_pkg::OP_READ: begin
                            cmd.rd_index = 1'b1;
                            state_next   = ST_READ;
                        end
                        pltr_pkg::OP_WRITE: begin
                            cmd.wr_item = 1'b1;
                        end
                        pltr_pkg::OP_FIND: begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (out_free) begin
                    cmd.load_read = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (stat.scan_hit || stat.scan_last) begin
                    if (out_free) begin
                        cmd.load_find = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (cmd.load_read || cmd.load_find) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    `PLTR_ASSERT(a_cmd_onehot, $onehot0(cmd), "More than one datapath command issued.")
    `PLTR_ASSERT(a_load_room, (cmd.load_read || cmd.load_find) |-> out_free, "Result loaded over a pending result.")
    `PLTR_ASSERT(a_read_result, (state_reg == ST_READ) |=> m_valid_reg, "Read finished without a result.")
    `PLTR_ASSERT_NR(a_reset_clear, !aresetn |=> !s_ready, "Requests taken before the clearing pass.")

endmodule

[rtl/pltr_dpath.sv]
// -----------------------------------------------------------------------------
// Palette table datapath
// Configuration registers, palette RAM, scan counter and result registers.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module pltr_dpath #(
    parameter int PALETTE_DEPTH = pltr_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_write,
    input  logic [pltr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pltr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [pltr_pkg::IDX_W-1:0]      s_index,
    input  logic [pltr_pkg::CHAN_W-1:0]     s_red,
    input  logic [pltr_pkg::CHAN_W-1:0]     s_green,
    input  logic [pltr_pkg::CHAN_W-1:0]     s_blue,
    input  pltr_pkg::cmd_t                  cmd,
    output pltr_pkg::stat_t                 stat,
    output logic [pltr_pkg::CHAN_W-1:0]     m_out_red,
    output logic [pltr_pkg::CHAN_W-1:0]     m_out_green,
    output logic [pltr_pkg::CHAN_W-1:0]     m_out_blue,
    output logic [pltr_pkg::IDX_W-1:0]      m_found_index,
    output logic                            m_found
);

    localparam int AW    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int LIMIT = (PALETTE_DEPTH < pltr_pkg::SEARCH_MAX) ?
                           PALETTE_DEPTH : pltr_pkg::SEARCH_MAX;
    localparam logic [pltr_pkg::LEN_W-1:0] LIMIT_LEN  = pltr_pkg::LEN_W'(LIMIT);
    localparam logic [AW-1:0]              CLEAR_LAST = AW'(PALETTE_DEPTH - 1);

    logic [pltr_pkg::LEN_W-1:0]   palette_length_reg;
    logic [pltr_pkg::BG_W-1:0]    background_id_reg;
    logic [AW-1:0]                clear_cnt_reg;
    logic [AW-1:0]                clear_cnt_next;
    logic [pltr_pkg::IDX_W-1:0]   scan_cnt_reg;
    logic [pltr_pkg::IDX_W-1:0]   scan_cnt_next;
    logic [pltr_pkg::COLOR_W-1:0] color_reg;
    logic [pltr_pkg::CHAN_W-1:0]  out_red_reg;
    logic [pltr_pkg::CHAN_W-1:0]  out_green_reg;
    logic [pltr_pkg::CHAN_W-1:0]  out_blue_reg;
    logic [pltr_pkg::IDX_W-1:0]   found_index_reg;
    logic                         found_reg;

    logic [pltr_pkg::LEN_W-1:0]   eff_len;
    logic [pltr_pkg::IDX_W-1:0]   last_idx;
    logic [pltr_pkg::IDX_W-1:0]   clamped_idx;
    logic [pltr_pkg::COLOR_W-1:0] s_color;
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [pltr_pkg::COLOR_W-1:0] ram_wdata;
    logic                         ram_re;
    logic [AW-1:0]                ram_raddr;
    logic [pltr_pkg::COLOR_W-1:0] ram_rdata;

    // A length of zero acts as one; the length saturates at the searchable span.
    always_comb begin
        if (palette_length_reg == '0) begin
            eff_len = pltr_pkg::LEN_W'(1);
        end else if (palette_length_reg > LIMIT_LEN) begin
            eff_len = LIMIT_LEN;
        end else begin
            eff_len = palette_length_reg;
        end
    end

    assign last_idx    = pltr_pkg::IDX_W'(eff_len - pltr_pkg::LEN_W'(1));
    assign clamped_idx = (s_index > last_idx) ? last_idx : s_index;
    assign s_color     = {s_red, s_green, s_blue};

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = clear_cnt_reg;
        ram_wdata = '0;
        if (cmd.wr_item) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(clamped_idx);
            ram_wdata = s_color;
        end else if (cmd.clear_step) begin
            ram_we = 1'b1;
        end
    end

    always_comb begin
        ram_re    = cmd.rd_index || cmd.scan_start || cmd.scan_step;
        ram_raddr = '0;
        if (cmd.rd_index) begin
            ram_raddr = AW'(clamped_idx);
        end else if (cmd.scan_step) begin
            ram_raddr = AW'(scan_cnt_next);
        end
    end

    always_comb begin
        scan_cnt_next = scan_cnt_reg;
        if (cmd.scan_start) begin
            scan_cnt_next = '0;
        end else if (cmd.scan_step) begin
            scan_cnt_next = scan_cnt_reg + pltr_pkg::IDX_W'(1);
        end
    end

    assign clear_cnt_next = cmd.clear_step ? (clear_cnt_reg + AW'(1)) : clear_cnt_reg;

    assign stat.clear_last = (clear_cnt_reg == CLEAR_LAST);
    assign stat.scan_hit   = (ram_rdata == color_reg);
    assign stat.scan_last  = (scan_cnt_reg == last_idx);

    pltr_ram #(
        .WIDTH (pltr_pkg::COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            palette_length_reg <= pltr_pkg::LENGTH_RESET;
            background_id_reg  <= '0;
            clear_cnt_reg      <= '0;
        end else begin
            clear_cnt_reg <= clear_cnt_next;
            if (cfg_write) begin
                unique case (cfg_index)
                    pltr_pkg::CFG_PALETTE_LENGTH: begin
                        palette_length_reg <= pltr_pkg::LEN_W'(cfg_data);
                    end
                    pltr_pkg::CFG_BACKGROUND_ID: begin
                        background_id_reg <= pltr_pkg::BG_W'(cfg_data);
                    end
                    default: begin
                        background_id_reg <= background_id_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        scan_cnt_reg <= scan_cnt_next;
        if (cmd.scan_start) begin
            color_reg <= s_color;
        end
        if (cmd.load_read) begin
            out_red_reg     <= ram_rdata[3*pltr_pkg::CHAN_W-1:2*pltr_pkg::CHAN_W];
            out_green_reg   <= ram_rdata[2*pltr_pkg::CHAN_W-1:pltr_pkg::CHAN_W];
            out_blue_reg    <= ram_rdata[pltr_pkg::CHAN_W-1:0];
            found_index_reg <= '0;
            found_reg       <= 1'b0;
        end else if (cmd.load_find) begin
            out_red_reg     <= '0;
            out_green_reg   <= '0;
            out_blue_reg    <= '0;
            found_index_reg <= stat.scan_hit ? scan_cnt_reg : '0;
            found_reg       <= stat.scan_hit;
        end
    end

    assign m_out_red     = out_red_reg;
    assign m_out_green   = out_green_reg;
    assign m_out_blue    = out_blue_reg;
    assign m_found_index = found_index_reg;
    assign m_found       = found_reg;

    `PLTR_ASSERT(a_bg_hold, !cfg_write |=> $stable(background_id_reg), "Background id changed without a write.")
    `PLTR_ASSERT(a_len_hold, !cfg_write |=> $stable(palette_length_reg), "Palette length changed without a write.")
    `PLTR_ASSERT(a_clear_step, (cmd.clear_step && !stat.clear_last) |=> (clear_cnt_reg == AW'($past(clear_cnt_reg) + AW'(1))), "Clearing pass skipped an entry.")

endmodule

[rtl/palette_table_with_reverse_lookup_top.sv]
// -----------------------------------------------------------------------------
// Palette table with reverse lookup
// RGB palette store with read, write and first-match color search.
// -----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  s_       in         s_valid / s_ready     operation, index, red, green, blue
//  m_       out        m_valid / m_ready     out_red, out_green, out_blue, found_index, found
//  cfg_     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Writes are taken back to back; a read is limited by the registered RAM read port.
// A search reads one palette entry per cycle and stops at the first match or
// after L entries, where L is the effective palette length, at most 256.
// After reset a clearing pass writes zero to all PALETTE_DEPTH entries, one per
// cycle, while no request is taken; configuration writes are taken at any time.
// A result waiting in the output register stalls only the next read or search.
// -----------------------------------------------------------------------------
module palette_table_with_reverse_lookup_top #(
    parameter int PALETTE_DEPTH = pltr_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pltr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pltr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [pltr_pkg::OP_W-1:0]       s_operation,
    input  logic [pltr_pkg::IDX_W-1:0]      s_index,
    input  logic [pltr_pkg::CHAN_W-1:0]     s_red,
    input  logic [pltr_pkg::CHAN_W-1:0]     s_green,
    input  logic [pltr_pkg::CHAN_W-1:0]     s_blue,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [pltr_pkg::CHAN_W-1:0]     m_out_red,
    output logic [pltr_pkg::CHAN_W-1:0]     m_out_green,
    output logic [pltr_pkg::CHAN_W-1:0]     m_out_blue,
    output logic [pltr_pkg::IDX_W-1:0]      m_found_index,
    output logic                            m_found
);

    pltr_pkg::cmd_t  cmd;
    pltr_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    pltr_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    pltr_dpath #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_index       (s_index),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .cmd           (cmd),
        .stat          (stat),
        .m_out_red     (m_out_red),
        .m_out_green   (m_out_green),
        .m_out_blue    (m_out_blue),
        .m_found_index (m_found_index),
        .m_found       (m_found)
    );

endmodule

[tb/tb.sv]
// -----------------------------------------------------------------------------
// Palette table with reverse lookup testbench
// Drives read, write, color-search and spare-code requests into the palette
// table. A shadow copy of the palette and the length register predicts each
// result that a directed row does not give, and each returned result is
// compared field by field in arrival order. A directed table comes first.
// Random phases follow, each under its own palette length and background id,
// with random request gaps and result stalls, each off in some phases.
// -----------------------------------------------------------------------------
module tb;

    localparam int DEPTH = pltr_pkg::PALETTE_DEPTH_DEF;
    localparam int PHASES = 12;
    localparam int PHASE_REQUESTS = 86;
    localparam int IDLE_GUARD = 8;
    localparam int SETTLE_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT = 1_500_000;

    localparam logic [pltr_pkg::OP_W-1:0] OP_SPARE = 2'd3;
    localparam logic [pltr_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [pltr_pkg::CHAN_W-1:0] red;
        logic [pltr_pkg::CHAN_W-1:0] green;
        logic [pltr_pkg::CHAN_W-1:0] blue;
        logic [pltr_pkg::IDX_W-1:0]  found_index;
        logic                        found;
    } palette_result_t;

    typedef struct packed {
        logic [pltr_pkg::OP_W-1:0]   op;
        logic [pltr_pkg::IDX_W-1:0]  idx;
        logic [pltr_pkg::CHAN_W-1:0] red;
        logic [pltr_pkg::CHAN_W-1:0] green;
        logic [pltr_pkg::CHAN_W-1:0] blue;
        bit                          typed;
        palette_result_t             want;
    } stim_row_t;

    localparam palette_result_t ALL_CLEAR = '0;

    logic aclk = 1'b0;
    logic aresetn;
    logic cfg_valid;
    logic cfg_ready;
    logic [pltr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [pltr_pkg::CFG_DATA_W-1:0] cfg_data;
    logic s_valid;
    logic s_ready;
    logic [pltr_pkg::OP_W-1:0] s_operation;
    logic [pltr_pkg::IDX_W-1:0] s_index;
    logic [pltr_pkg::CHAN_W-1:0] s_red;
    logic [pltr_pkg::CHAN_W-1:0] s_green;
    logic [pltr_pkg::CHAN_W-1:0] s_blue;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [pltr_pkg::CHAN_W-1:0] m_out_red;
    logic [pltr_pkg::CHAN_W-1:0] m_out_green;
    logic [pltr_pkg::CHAN_W-1:0] m_out_blue;
    logic [pltr_pkg::IDX_W-1:0] m_found_index;
    logic m_found;

    palette_table_with_reverse_lookup_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_index       (s_index),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_red     (m_out_red),
        .m_out_green   (m_out_green),
        .m_out_blue    (m_out_blue),
        .m_found_index (m_found_index),
        .m_found       (m_found)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Shadow state of the palette table.
    logic [pltr_pkg::COLOR_W-1:0] shadow_palette [DEPTH];
    logic [pltr_pkg::LEN_W-1:0] length_reg;
    logic [pltr_pkg::BG_W-1:0] background_reg;
    logic [pltr_pkg::COLOR_W-1:0] swatches [8];

    palette_result_t pending_results [$];

    int unsigned mismatches = 0;
    int unsigned results_checked = 0;
    int unsigned cycle_count = 0;
    int unsigned n_reads = 0;
    int unsigned n_writes = 0;
    int unsigned n_finds = 0;
    int unsigned n_hits = 0;
    int unsigned n_spare = 0;
    int unsigned n_cfg = 0;
    bit source_steady = 1'b0;
    logic sink_steady = 1'b0;
    int unsigned sink_hold = 0;

    stim_row_t directed_rows [23] = '{
        '{pltr_pkg::OP_READ, 8'd0, 8'h00, 8'h00, 8'h00, 1'b1, ALL_CLEAR},
        '{pltr_pkg::OP_READ, 8'd255, 8'hFF, 8'hFF, 8'hFF, 1'b1, ALL_CLEAR},
        '{pltr_pkg::OP_FIND, 8'd0, 8'h00, 8'h00, 8'h00, 1'b1,
          '{8'h00, 8'h00, 8'h00, 8'd0, 1'b1}},
        '{pltr_pkg::OP_FIND, 8'd255, 8'hFF, 8'hFF, 8'hFF, 1'b1, ALL_CLEAR},
        '{OP_SPARE, 8'd5, 8'hFF, 8'hFF, 8'hFF, 1'b1, ALL_CLEAR},
        '{pltr_pkg::OP_WRITE, 8'd255, 8'hFF, 8'hFF, 8'hFF, 1'b1, ALL_CLEAR},
        '{pltr_pkg::OP_READ, 8'd255, 8'h00, 8'h00, 8'h00, 1'b1,
          '{8'hFF, 8'hFF, 8'hFF, 8'd0, 1'b0}},
        '{pltr_pkg::OP_FIND, 8'd0, 8'hFF, 8'hFF, 8'hFF, 1'b1,
          '{8'h00, 8'h00, 8'h00, 8'd255, 1'b1}},
        '{pltr_pkg::OP_WRITE, 8'd0, 8'h12, 8'h34, 8'h56, 1'b1, ALL_CLEAR},
        '{pltr_pkg::OP_FIND, 8'd77, 8'h00, 8'h00, 8'h00, 1'b1,
          '{8'h00, 8'h00, 8'h00, 8'd1, 1'b1}},
        '{pltr_pkg::OP_WRITE, 8'd1, 8'h12, 8'h34, 8'h56, 1'b1, ALL_CLEAR},
        '{pltr_pkg::OP_FIND, 8'd0, 8'h12, 8'h34, 8'h56, 1'b1,
          '{8'h00, 8'h00, 8'h00, 8'd0, 1'b1}},
        '{pltr_pkg::OP_WRITE, 8'd0, 8'hAA, 8'h55, 8'h0F, 1'b1, ALL_CLEAR},
        '{pltr_pkg::OP_FIND, 8'd0, 8'h12, 8'h34, 8'h56, 1'b1,
          '{8'h00, 8'h00, 8'h00, 8'd1, 1'b1}},
        '{pltr_pkg::OP_READ, 8'd0, 8'h00, 8'h00, 8'h00, 1'b1,
          '{8'hAA, 8'h55, 8'h0F, 8'd0, 1'b0}},
        '{pltr_pkg::OP_WRITE, 8'd128, 8'h00, 8'hFF, 8'h00, 1'b1, ALL_CLEAR},
        '{pltr_pkg::OP_READ, 8'd128, 8'hFF, 8'h00, 8'hFF, 1'b0, ALL_CLEAR},
        '{pltr_pkg::OP_FIND, 8'd3, 8'h00, 8'hFF, 8'h00, 1'b0, ALL_CLEAR},
        '{pltr_pkg::OP_FIND, 8'd0, 8'h00, 8'hFF, 8'h01, 1'b1, ALL_CLEAR},
        '{pltr_pkg::OP_WRITE, 8'd200, 8'h80, 8'h80, 8'h80, 1'b1, ALL_CLEAR},
        '{pltr_pkg::OP_FIND, 8'd0, 8'h80, 8'h80, 8'h80, 1'b0, ALL_CLEAR},
        '{OP_SPARE, 8'd255, 8'hFF, 8'hFF, 8'hFF, 1'b1, ALL_CLEAR},
        '{pltr_pkg::OP_READ, 8'd200, 8'h00, 8'h00, 8'h00, 1'b0, ALL_CLEAR}
    };

    function automatic int active_entries();
        int n;
        n = length_reg;
        if (n == 0) n = 1;
        if (n > DEPTH) n = DEPTH;
        return n;
    endfunction

    function automatic int clamp_slot(logic [pltr_pkg::IDX_W-1:0] idx);
        int n;
        n = active_entries();
        return (int'(idx) > n - 1) ? n - 1 : int'(idx);
    endfunction

    function automatic int unsigned pick_pause();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) return $urandom_range(1, 3);
        if (sel < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic predict_palette_op(input logic [pltr_pkg::OP_W-1:0] op,
                                      input logic [pltr_pkg::IDX_W-1:0] idx,
                                      input logic [pltr_pkg::COLOR_W-1:0] color,
                                      output bit has_result, output palette_result_t res);
        int n;
        logic [pltr_pkg::COLOR_W-1:0] entry;
        has_result = 1'b0;
        res = '0;
        case (op)
            pltr_pkg::OP_READ: begin
                entry = shadow_palette[clamp_slot(idx)];
                res.red = entry[23:16];
                res.green = entry[15:8];
                res.blue = entry[7:0];
                has_result = 1'b1;
                n_reads++;
            end
            pltr_pkg::OP_WRITE: begin
                shadow_palette[clamp_slot(idx)] = color;
                n_writes++;
            end
            pltr_pkg::OP_FIND: begin
                n = active_entries();
                if (n > pltr_pkg::SEARCH_MAX) n = pltr_pkg::SEARCH_MAX;
                for (int i = 0; i < n; i++) begin
                    if (shadow_palette[i] == color) begin
                        res.found_index = pltr_pkg::IDX_W'(i);
                        res.found = 1'b1;
                        break;
                    end
                end
                has_result = 1'b1;
                n_finds++;
                if (res.found) n_hits++;
            end
            default: begin
                n_spare++;
            end
        endcase
    endtask

    task automatic issue_request(input logic [pltr_pkg::OP_W-1:0] op,
                                 input logic [pltr_pkg::IDX_W-1:0] idx,
                                 input logic [pltr_pkg::COLOR_W-1:0] color, input bit use_typed,
                                 input palette_result_t typed_res);
        bit has_result;
        palette_result_t res;
        s_valid <= 1'b1;
        s_operation <= op;
        s_index <= idx;
        s_red <= color[23:16];
        s_green <= color[15:8];
        s_blue <= color[7:0];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_palette_op(op, idx, color, has_result, res);
        if (has_result) pending_results.push_back(use_typed ? typed_res : res);
    endtask

    task automatic source_gap();
        int unsigned gap;
        gap = (source_steady || $urandom_range(0, 1) == 0) ? 0 : pick_pause();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic write_register(input logic [pltr_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [pltr_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == pltr_pkg::CFG_PALETTE_LENGTH) length_reg = data;
        else if (idx == pltr_pkg::CFG_BACKGROUND_ID) background_reg = data[pltr_pkg::BG_W-1:0];
        n_cfg++;
    endtask

    task automatic random_request(output bit ignored);
        int unsigned sel;
        int unsigned pick;
        int reach;
        logic [pltr_pkg::OP_W-1:0] op;
        logic [pltr_pkg::IDX_W-1:0] idx;
        logic [pltr_pkg::COLOR_W-1:0] color;
        sel = $urandom_range(0, 99);
        op = (sel < 40) ? pltr_pkg::OP_WRITE :
             (sel < 65) ? pltr_pkg::OP_READ :
             (sel < 96) ? pltr_pkg::OP_FIND : OP_SPARE;
        reach = active_entries() + 1;
        if (reach > 255) reach = 255;
        idx = ($urandom_range(0, 3) == 0) ? pltr_pkg::IDX_W'($urandom) :
                                            pltr_pkg::IDX_W'($urandom_range(0, reach));
        pick = $urandom_range(0, 9);
        if (op == pltr_pkg::OP_FIND && pick < 5)
            color = shadow_palette[$urandom_range(0, active_entries() - 1)];
        else if (pick < 7)
            color = swatches[$urandom_range(0, 7)];
        else if (pick < 9)
            color = pltr_pkg::COLOR_W'($urandom);
        else
            color = '0;
        issue_request(op, idx, color, 1'b0, ALL_CLEAR);
        ignored = (op == OP_SPARE);
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatches < 40)
            $display("MISMATCH at %0t: %s got 0x%0h, wanted 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!sink_steady && $urandom_range(0, 3) == 0) sink_hold <= pick_pause();
        end
    end

    always @(posedge aclk) begin
        palette_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending, found_index",
                                m_found_index, 0);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_out_red !== want.red) report_mismatch("out_red", m_out_red, want.red);
                if (m_out_green !== want.green)
                    report_mismatch("out_green", m_out_green, want.green);
                if (m_out_blue !== want.blue)
                    report_mismatch("out_blue", m_out_blue, want.blue);
                if (m_found_index !== want.found_index)
                    report_mismatch("found_index", m_found_index, want.found_index);
                if (m_found !== want.found) report_mismatch("found", m_found, want.found);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results.size());
            $display("palette_table_with_reverse_lookup_top regression: fail");
            $finish;
        end
    end

    initial begin
        int unsigned length_plan [PHASES];
        int unsigned counted;
        logic [pltr_pkg::LEN_W-1:0] length_value;
        logic [pltr_pkg::BG_W-1:0] bg_value;
        bit ignored;
        length_plan = '{0, 1, 2, 511, 256, 5, 16, 40, 257, 8, 0, 0};
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= pltr_pkg::CFG_PALETTE_LENGTH;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_operation <= pltr_pkg::OP_READ;
        s_index <= '0;
        s_red <= '0;
        s_green <= '0;
        s_blue <= '0;
        foreach (shadow_palette[i]) shadow_palette[i] = '0;
        length_reg = pltr_pkg::LENGTH_RESET;
        background_reg = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[k]) begin
            issue_request(directed_rows[k].op, directed_rows[k].idx,
                          {directed_rows[k].red, directed_rows[k].green, directed_rows[k].blue},
                          directed_rows[k].typed, directed_rows[k].want);
            source_gap();
        end

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            repeat (IDLE_GUARD) @(posedge aclk);
            if (p == 10) length_value = pltr_pkg::LEN_W'($urandom_range(3, 64));
            else if (p == 11) length_value = pltr_pkg::LEN_W'($urandom_range(0, 511));
            else length_value = pltr_pkg::LEN_W'(length_plan[p]);
            bg_value = (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : pltr_pkg::BG_W'($urandom);
            write_register(pltr_pkg::CFG_PALETTE_LENGTH, length_value);
            write_register(pltr_pkg::CFG_BACKGROUND_ID, pltr_pkg::CFG_DATA_W'(bg_value));
            if (p == 2) write_register(CFG_SPARE, 9'h1FF);
            cfg_valid <= 1'b0;
            foreach (swatches[i]) swatches[i] = pltr_pkg::COLOR_W'($urandom);
            source_steady = (p % 4 == 1);
            sink_steady <= (p % 3 == 2);
            counted = 0;
            while (counted < PHASE_REQUESTS) begin
                random_request(ignored);
                if (!ignored) counted++;
                source_gap();
                if (p % 2 == 0 && counted == PHASE_REQUESTS / 2) drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Ran %0d reads, %0d writes, %0d lookups (%0d hits), %0d spare codes;",
                 n_reads, n_writes, n_finds, n_hits, n_spare);
        $display("%0d results, %0d register writes across %0d length settings, %0d mismatches.",
                 results_checked, n_cfg, PHASES + 1, mismatches);
        if (mismatches == 0) begin
            $display("palette_table_with_reverse_lookup_top regression: pass");
        end else begin
            $display("palette_table_with_reverse_lookup_top regression: fail");
        end
        $finish;
    end

endmodule
